### design/vna_pkg.sv
// Package: shared types, constants and helpers for the vertex normal accumulator.
package vna_pkg;

    localparam int VERTEX_COUNT_DEF = 1024;
    localparam int IDX_W   = 10;
    localparam int POS_W   = 16;
    localparam int SUM_W   = 24;
    localparam int UNIT_W  = 16;
    localparam int CMD_W   = 2 + 3 * IDX_W + 3 * POS_W;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_TRI  = 2'd1,
        FUNC_READ = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef struct packed {
        func_t              func;
        logic [IDX_W-1:0]   vertex_a;
        logic [IDX_W-1:0]   vertex_b;
        logic [IDX_W-1:0]   vertex_c;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [POS_W-1:0]   pos_z;
        logic               in_range;
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_EDGE,
        ST_CROSS1,
        ST_CROSS2,
        ST_ABS,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_NRD,
        ST_NWAIT,
        ST_NWR,
        ST_RREAD,
        ST_RWAIT,
        ST_OUT
    } state_t;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] acc,
        input logic signed [UNIT_W-1:0] d
    );
        logic signed [SUM_W:0] t;
        begin
            t = {acc[SUM_W-1], acc} + {{(SUM_W+1-UNIT_W){d[UNIT_W-1]}}, d};
            if (t[SUM_W] != t[SUM_W-1]) begin
                sat_add = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
                sat_add = t[SUM_W-1:0];
            end
        end
    endfunction

endpackage

### design/vna_front.sv
// Front end: accepts input words, range-checks indices, queues commands.
module vna_front
    import vna_pkg::*;
#(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [CMD_W-1:0]   s_tdata,
    output logic               q_valid,
    input  logic               q_ready,
    output cmd_t               q_cmd
);

    cmd_t       slot_reg [QUEUE_DEPTH];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    cmd_t       in_cmd;
    logic       push, pop;

    always_comb begin
        in_cmd.func     = func_t'(s_tdata[1:0]);
        in_cmd.vertex_a = s_tdata[2 +: IDX_W];
        in_cmd.vertex_b = s_tdata[2 + IDX_W +: IDX_W];
        in_cmd.vertex_c = s_tdata[2 + 2*IDX_W +: IDX_W];
        in_cmd.pos_x    = s_tdata[2 + 3*IDX_W +: POS_W];
        in_cmd.pos_y    = s_tdata[2 + 3*IDX_W + POS_W +: POS_W];
        in_cmd.pos_z    = s_tdata[2 + 3*IDX_W + 2*POS_W +: POS_W];
        in_cmd.in_range = ({22'd0, in_cmd.vertex_a} < 32'(VERTEX_COUNT));
        if (in_cmd.func == FUNC_TRI) begin
            in_cmd.in_range = in_cmd.in_range
                && ({22'd0, in_cmd.vertex_b} < 32'(VERTEX_COUNT))
                && ({22'd0, in_cmd.vertex_c} < 32'(VERTEX_COUNT));
        end
    end

    assign s_tready = (count_reg != 2'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= in_cmd;
    end

    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= 2'(QUEUE_DEPTH))
        else $error("queue overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0) |-> !q_valid)
        else $error("empty queue offers a command");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count lost a push");

endmodule

### design/vna_sqrt.sv
// Iterative integer square root, one root bit per cycle.
module vna_sqrt
    import vna_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [63:0]   radicand,
    output logic          done,
    output logic [31:0]   root
);

    logic [63:0] rem_reg;
    logic [63:0] rad_reg;
    logic [31:0] root_reg;
    logic [5:0]  step_reg;
    logic        busy_reg;
    logic [65:0] trial;
    logic [65:0] rem_sh;

    assign rem_sh = {rem_reg, rad_reg[63:62]};
    assign trial  = {32'd0, root_reg, 2'b01};
    assign root   = root_reg;
    assign done   = busy_reg && (step_reg == 6'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 6'd0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= 6'd32;
            rem_reg  <= 64'd0;
            root_reg <= 32'd0;
            rad_reg  <= radicand;
        end else if (busy_reg) begin
            if (step_reg == 6'd0) begin
                busy_reg <= 1'b0;
            end else begin
                step_reg <= step_reg - 6'd1;
                rad_reg  <= {rad_reg[61:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_reg  <= 64'(rem_sh - trial);
                    root_reg <= {root_reg[30:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh[63:0];
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) done |=> !busy_reg)
        else $error("sqrt done held");
    assert property (@(posedge aclk) disable iff (!aresetn) start |=> busy_reg)
        else $error("sqrt did not start");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && step_reg != 6'd0 && !start) |=> (step_reg == $past(step_reg) - 6'd1))
        else $error("sqrt step skipped");

endmodule

### design/vna_back.sv
// Back end: position and normal memories, triangle datapath, read results.
module vna_back
    import vna_pkg::*;
#(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  cmd_t                 q_cmd,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [IDX_W+3*SUM_W-1:0] m_tdata
);

    localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

    logic [3*POS_W-1:0] pos_mem  [VERTEX_COUNT];
    logic [3*SUM_W-1:0] norm_mem [VERTEX_COUNT];

    state_t state_reg, state_next;
    cmd_t   cmd_reg;

    logic [AW-1:0]        paddr;
    logic [3*POS_W-1:0]   prd_reg;
    logic [AW-1:0]        naddr;
    logic [3*SUM_W-1:0]   nrd_reg;
    logic                 nwe;
    logic [3*SUM_W-1:0]   nwdata;
    logic                 pwe;

    logic signed [POS_W-1:0] pa_reg [3];
    logic signed [POS_W-1:0] pb_reg [3];
    logic signed [POS_W:0]   e1_reg [3];
    logic signed [POS_W:0]   e2_reg [3];
    logic signed [33:0]      p1_reg [3];
    logic signed [33:0]      p2_reg [3];
    logic signed [34:0]      cr_reg [3];
    logic [34:0]             mag_reg [3];
    logic [31:0]             m_reg [3];
    logic [63:0]             s_reg;
    logic [1:0]              vsel_reg;
    logic [1:0]              dcomp_reg;
    logic [5:0]              dstep_reg;
    logic [47:0]             dnum_reg;
    logic [32:0]             drem_reg;
    logic [14:0]             dq_reg;
    logic signed [UNIT_W-1:0] u_reg [3];
    logic [1:0]              sq_reg;
    logic                    sq_start;
    logic                    sq_done;
    logic [31:0]             sq_root;
    logic                    degen;
    logic [34:0]             top;
    logic [AW-1:0]           ia, ib, ic;

    assign ia = cmd_reg.vertex_a[AW-1:0];
    assign ib = cmd_reg.vertex_b[AW-1:0];
    assign ic = cmd_reg.vertex_c[AW-1:0];

    vna_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (s_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_comb begin
        top = mag_reg[0];
        if (mag_reg[1] > top) top = mag_reg[1];
        if (mag_reg[2] > top) top = mag_reg[2];
        degen = (top == 35'd0);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (!q_cmd.in_range && q_cmd.func == FUNC_READ) state_next = ST_OUT;
                    else if (!q_cmd.in_range) state_next = ST_IDLE;
                    else begin
                        case (q_cmd.func)
                            FUNC_LOAD: state_next = ST_LOAD;
                            FUNC_TRI:  state_next = ST_RD_A;
                            FUNC_READ: state_next = ST_RREAD;
                            default:   state_next = ST_IDLE;
                        endcase
                    end
                end
            end
            ST_LOAD:   state_next = ST_IDLE;
            ST_RD_A:   state_next = ST_RD_B;
            ST_RD_B:   state_next = ST_RD_C;
            ST_RD_C:   state_next = ST_EDGE;
            ST_EDGE:   state_next = ST_CROSS1;
            ST_CROSS1: state_next = ST_CROSS2;
            ST_CROSS2: state_next = ST_ABS;
            ST_ABS:    state_next = ST_NORM;
            ST_NORM: begin
                if (degen) state_next = ST_IDLE;
                else if (top >= 35'h80000000 || top < 35'h40000000) state_next = ST_NORM;
                else state_next = ST_SQ;
            end
            ST_SQ:     state_next = (sq_reg == 2'd3) ? ST_SQRT : ST_SQ;
            ST_SQRT:   state_next = sq_done ? ST_DIV : ST_SQRT;
            ST_DIV:    state_next = (dstep_reg == 6'd0 && dcomp_reg == 2'd2) ? ST_NRD : ST_DIV;
            ST_NRD:    state_next = ST_NWAIT;
            ST_NWAIT:  state_next = ST_NWR;
            ST_NWR:    state_next = (vsel_reg == 2'd2) ? ST_IDLE : ST_NRD;
            ST_RREAD:  state_next = ST_RWAIT;
            ST_RWAIT:  state_next = ST_OUT;
            ST_OUT:    state_next = m_tready ? ST_IDLE : ST_OUT;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_ready  = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_OUT);
        sq_start = (state_reg == ST_SQ) && (sq_reg == 2'd3);
        pwe      = (state_reg == ST_LOAD);
        nwe      = (state_reg == ST_LOAD) || (state_reg == ST_NWR);
        paddr    = ia;
        case (state_reg)
            ST_RD_B: paddr = ib;
            ST_RD_C: paddr = ic;
            default: paddr = ia;
        endcase
        naddr = ia;
        if (state_reg == ST_NRD || state_reg == ST_NWAIT || state_reg == ST_NWR) begin
            case (vsel_reg)
                2'd1:    naddr = ib;
                2'd2:    naddr = ic;
                default: naddr = ia;
            endcase
        end
        if (state_reg == ST_LOAD) begin
            nwdata = '0;
        end else begin
            nwdata = {sat_add(nrd_reg[2*SUM_W +: SUM_W], u_reg[2]),
                      sat_add(nrd_reg[SUM_W +: SUM_W],   u_reg[1]),
                      sat_add(nrd_reg[0 +: SUM_W],       u_reg[0])};
        end
        m_tdata = cmd_reg.in_range ? {nrd_reg, cmd_reg.vertex_a}
                                   : {{(3*SUM_W){1'b0}}, cmd_reg.vertex_a};
    end

    always_ff @(posedge aclk) begin
        if (pwe) pos_mem[paddr] <= {cmd_reg.pos_z, cmd_reg.pos_y, cmd_reg.pos_x};
        prd_reg <= pos_mem[paddr];
    end

    always_ff @(posedge aclk) begin
        if (nwe) norm_mem[naddr] <= nwdata;
        nrd_reg <= norm_mem[naddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid) cmd_reg <= q_cmd;
        case (state_reg)
            ST_RD_B: for (int i = 0; i < 3; i++) pa_reg[i] <= prd_reg[i*POS_W +: POS_W];
            ST_RD_C: for (int i = 0; i < 3; i++) pb_reg[i] <= prd_reg[i*POS_W +: POS_W];
            ST_EDGE: begin
                for (int i = 0; i < 3; i++) begin
                    e1_reg[i] <= {pb_reg[i][POS_W-1], pb_reg[i]} - {pa_reg[i][POS_W-1], pa_reg[i]};
                    e2_reg[i] <= (POS_W+1)'($signed(prd_reg[i*POS_W +: POS_W]))
                               - {pa_reg[i][POS_W-1], pa_reg[i]};
                end
            end
            ST_CROSS1: begin
                p1_reg[0] <= e1_reg[1] * e2_reg[2];
                p2_reg[0] <= e1_reg[2] * e2_reg[1];
                p1_reg[1] <= e1_reg[2] * e2_reg[0];
                p2_reg[1] <= e1_reg[0] * e2_reg[2];
                p1_reg[2] <= e1_reg[0] * e2_reg[1];
                p2_reg[2] <= e1_reg[1] * e2_reg[0];
            end
            ST_CROSS2: for (int i = 0; i < 3; i++)
                cr_reg[i] <= {p1_reg[i][33], p1_reg[i]} - {p2_reg[i][33], p2_reg[i]};
            ST_ABS: begin
                for (int i = 0; i < 3; i++)
                    mag_reg[i] <= cr_reg[i][34] ? 35'(-cr_reg[i]) : 35'(cr_reg[i]);
                sq_reg <= 2'd0;
                s_reg  <= 64'd0;
            end
            ST_NORM: begin
                if (top >= 35'h80000000) begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                end else if (top < 35'h40000000) begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                end else begin
                    for (int i = 0; i < 3; i++) m_reg[i] <= mag_reg[i][31:0];
                end
            end
            ST_SQ: begin
                if (sq_reg != 2'd3) s_reg <= s_reg + m_reg[sq_reg] * m_reg[sq_reg];
                sq_reg <= sq_reg + 2'd1;
                dcomp_reg <= 2'd0;
                dstep_reg <= 6'd48;
            end
            ST_SQRT: if (sq_done) begin
                dnum_reg  <= {m_reg[0], 14'd0} + 48'(sq_root >> 1);
                drem_reg  <= 33'd0;
                dstep_reg <= 6'd48;
            end
            ST_DIV: begin
                if (dstep_reg != 6'd0) begin
                    dstep_reg <= dstep_reg - 6'd1;
                    dnum_reg  <= {dnum_reg[46:0], 1'b0};
                    if ({drem_reg[31:0], dnum_reg[47]} >= {1'b0, sq_root}) begin
                        drem_reg <= {drem_reg[31:0], dnum_reg[47]} - {1'b0, sq_root};
                        dq_reg   <= {dq_reg[13:0], 1'b1};
                    end else begin
                        drem_reg <= {drem_reg[31:0], dnum_reg[47]};
                        dq_reg   <= {dq_reg[13:0], 1'b0};
                    end
                end else begin
                    u_reg[dcomp_reg] <= cr_reg[dcomp_reg][34]
                        ? -UNIT_W'({1'b0, dq_reg})
                        :  UNIT_W'({1'b0, dq_reg});
                    if (dcomp_reg != 2'd2) begin
                        dcomp_reg <= dcomp_reg + 2'd1;
                        dstep_reg <= 6'd48;
                        drem_reg  <= 33'd0;
                        dnum_reg  <= {m_reg[dcomp_reg + 2'd1], 14'd0} + 48'(sq_root >> 1);
                    end
                    vsel_reg <= 2'd0;
                end
            end
            ST_NWR: vsel_reg <= vsel_reg + 2'd1;
            default: ;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped under stall");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NWR) |-> nwe)
        else $error("normal write missing");
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready |-> !m_tvalid)
        else $error("accepted command while result pending");

endmodule

### design/vertex_normal_accumulator.sv
// Top level: vertex normal accumulator with front queue and back datapath.
//
// Input stream s_*: one word per command. func 0 loads a vertex position and
// clears its normal sum, func 1 adds the unit face normal of a triangle to
// its three vertices, func 2 reads one vertex's normal sum, func 3 is dropped.
// Result stream m_*: one word per read, holding the index and the three
// saturated 24-bit normal sums.
// A triangle passes through the back end in steps: reads and cross product,
// normalizing shifts, squares, the one-bit-per-cycle square root, three
// divides on one shared unit, and three read-modify-writes on the single
// normal memory port. A read holds the back end until its result is taken.
// A degenerate triangle ends at the normalizing step and adds nothing.
// Commands are processed one at a time; a two-entry queue lets the input
// take words while the back end is busy.
// Reset clears control only; memory contents stay undefined until loaded.
// A stalled receiver holds the result and the back end; the queue then fills
// and s_tready drops.
module vertex_normal_accumulator
    import vna_pkg::*;
#(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // func, vertex_a, vertex_b, vertex_c, pos_x, pos_y, pos_z (80 bits)
    input  logic [CMD_W-1:0]          s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // vertex_index, normal_x, normal_y, normal_z (82 bits, padded to 88)
    output logic [87:0]               m_tdata
);

    logic q_valid, q_ready;
    cmd_t q_cmd;
    logic [IDX_W+3*SUM_W-1:0] res;

    vna_front #(.VERTEX_COUNT(VERTEX_COUNT)) u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .q_valid, .q_ready, .q_cmd
    );

    vna_back #(.VERTEX_COUNT(VERTEX_COUNT)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .m_tvalid, .m_tready, .m_tdata(res)
    );

    assign m_tdata = {6'd0, res};

endmodule

### bench/vertex_normal_accumulator_tb.sv
// Testbench for the vertex normal accumulator: directed table, saturation runs and random words.
`timescale 1ns / 1ps

module vertex_normal_accumulator_tb;
    import vna_pkg::*;

    typedef struct {
        func_t     func;
        bit [9:0]  va;
        bit [9:0]  vb;
        bit [9:0]  vc;
        bit [15:0] px;
        bit [15:0] py;
        bit [15:0] pz;
    } cmd_word_t;

    typedef struct {
        bit [9:0]  idx;
        bit [23:0] nx;
        bit [23:0] ny;
        bit [23:0] nz;
    } normal_word_t;

    typedef struct {
        cmd_word_t    cmd;
        bit           typed;
        normal_word_t sum;
    } dir_row_t;

    localparam int DIR_ROWS = 22;
    localparam int HOLD_CYCLES = 600;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [CMD_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [87:0] m_tdata;

    int pos_mem[1024][3];
    int sum_mem[1024][3];
    bit loaded[1024];
    int loaded_q[$];
    normal_word_t normal_q[$];
    int fails = 0;
    int burst_left = 0;
    bit hold_long = 1'b0;

    vertex_normal_accumulator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #40000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [63:0] root_floor(logic [63:0] s);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'h1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= root + bitv) begin
                s -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic bit face_unit(input longint cr[3], output int u[3]);
        logic [63:0] m[3];
        logic [63:0] top;
        logic [63:0] s;
        logic [63:0] r;
        top = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = cr[i] < 0 ? -cr[i] : cr[i];
            if (m[i] > top) top = m[i];
        end
        if (top == 0) return 1'b0;
        while (top >= (64'h1 << 31)) begin
            top >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (top < (64'h1 << 30)) begin
            top <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        for (int i = 0; i < 3; i++) s += m[i] * m[i];
        r = root_floor(s);
        for (int i = 0; i < 3; i++) begin
            u[i] = int'((m[i] * 16384 + (r >> 1)) / r);
            if (cr[i] < 0) u[i] = -u[i];
        end
        return 1'b1;
    endfunction

    function automatic int sum_sat(int acc, int d);
        longint t;
        t = longint'(acc) + d;
        if (t > 8388607) t = 8388607;
        if (t < -8388608) t = -8388608;
        return int'(t);
    endfunction

    function automatic bit apply_word(input cmd_word_t w, output normal_word_t r);
        longint e1[3];
        longint e2[3];
        longint cr[3];
        int u[3];
        int idx[3];
        r = '{default: 0};
        case (w.func)
            FUNC_LOAD: begin
                pos_mem[w.va][0] = int'($signed(w.px));
                pos_mem[w.va][1] = int'($signed(w.py));
                pos_mem[w.va][2] = int'($signed(w.pz));
                for (int i = 0; i < 3; i++) sum_mem[w.va][i] = 0;
                if (!loaded[w.va]) loaded_q.push_back(w.va);
                loaded[w.va] = 1'b1;
            end
            FUNC_TRI: begin
                idx = '{w.va, w.vb, w.vc};
                for (int i = 0; i < 3; i++) begin
                    e1[i] = longint'(pos_mem[idx[1]][i]) - pos_mem[idx[0]][i];
                    e2[i] = longint'(pos_mem[idx[2]][i]) - pos_mem[idx[0]][i];
                end
                cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
                cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
                cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
                if (face_unit(cr, u)) begin
                    for (int k = 0; k < 3; k++)
                        for (int i = 0; i < 3; i++)
                            sum_mem[idx[k]][i] = sum_sat(sum_mem[idx[k]][i], u[i]);
                end
            end
            FUNC_READ: begin
                r.idx = w.va;
                r.nx = sum_mem[w.va][0][23:0];
                r.ny = sum_mem[w.va][1][23:0];
                r.nz = sum_mem[w.va][2][23:0];
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic send_word(input cmd_word_t w, input bit typed, input normal_word_t texp);
        normal_word_t r;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {w.pz, w.py, w.px, w.vc, w.vb, w.va, w.func};
        do @(posedge aclk); while (!s_tready);
        if (apply_word(w, r)) normal_q.push_back(typed ? texp : r);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (normal_q.size() != 0) @(posedge aclk);
    endtask

    function automatic cmd_word_t mk(func_t f, int a, int b, int c, int x, int y, int z);
        cmd_word_t w;
        w.func = f;
        w.va = 10'(a); w.vb = 10'(b); w.vc = 10'(c);
        w.px = 16'(x); w.py = 16'(y); w.pz = 16'(z);
        return w;
    endfunction

    function automatic int pick_loaded();
        return loaded_q[$urandom_range(0, loaded_q.size() - 1)];
    endfunction

    function automatic int rand_pos();
        if ($urandom_range(0, 1)) return $urandom_range(0, 65535);
        return $urandom_range(0, 2047) - 1024;
    endfunction

    // receiver: stall patterns, plus one long hold-off on request
    initial begin
        int mode;
        int run_left;
        int hold_left;
        int phase;
        mode = 0;
        run_left = 0;
        hold_left = 0;
        phase = 0;
        forever begin
            @(posedge aclk);
            if (hold_long) begin
                hold_long = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (run_left == 0) begin
                mode = $urandom_range(0, 2);
                run_left = $urandom_range(20, 200);
            end
            run_left--;
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= (phase % 7 < 3);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        normal_word_t got;
        normal_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[9:0], m_tdata[33:10], m_tdata[57:34], m_tdata[81:58]};
            if (normal_q.size() == 0) begin
                $error("result with no read pending: index %0d", got.idx);
                fails++;
            end else begin
                want = normal_q.pop_front();
                if (got.idx != want.idx) begin
                    $error("vertex_index: expected %0d, got %0d", want.idx, got.idx);
                    fails++;
                end
                if (got.nx != want.nx) begin
                    $error("normal_x: expected %0d, got %0d", $signed(want.nx), $signed(got.nx));
                    fails++;
                end
                if (got.ny != want.ny) begin
                    $error("normal_y: expected %0d, got %0d", $signed(want.ny), $signed(got.ny));
                    fails++;
                end
                if (got.nz != want.nz) begin
                    $error("normal_z: expected %0d, got %0d", $signed(want.nz), $signed(got.nz));
                    fails++;
                end
            end
        end
    end

    initial begin
        dir_row_t dir_tab[DIR_ROWS];
        normal_word_t none;
        int r;
        int a;
        int b;
        int c;
        none = '{default: 0};
        dir_tab = '{
            '{mk(FUNC_LOAD, 0, 0, 0, 0, 0, 0), 1'b0, none},
            '{mk(FUNC_LOAD, 1, 0, 0, 256, 0, 0), 1'b0, none},
            '{mk(FUNC_LOAD, 2, 0, 0, 0, 256, 0), 1'b0, none},
            '{mk(FUNC_READ, 0, 0, 0, 0, 0, 0), 1'b1, '{10'd0, 24'd0, 24'd0, 24'd0}},
            '{mk(FUNC_TRI, 0, 1, 2, 0, 0, 0), 1'b0, none},
            '{mk(FUNC_READ, 1, 0, 0, 0, 0, 0), 1'b1, '{10'd1, 24'd0, 24'd0, 24'd16384}},
            '{mk(FUNC_TRI, 0, 2, 1, 0, 0, 0), 1'b0, none},
            '{mk(FUNC_READ, 2, 0, 0, 0, 0, 0), 1'b1, '{10'd2, 24'd0, 24'd0, 24'd0}},
            '{mk(FUNC_TRI, 0, 0, 1, 0, 0, 0), 1'b0, none},
            '{mk(FUNC_READ, 0, 0, 0, 0, 0, 0), 1'b1, '{10'd0, 24'd0, 24'd0, 24'd0}},
            '{mk(FUNC_NONE, 1023, 1023, 1023, 16'hffff, 16'hffff, 16'hffff), 1'b0, none},
            '{mk(FUNC_LOAD, 3, 0, 0, 512, 0, 0), 1'b0, none},
            '{mk(FUNC_TRI, 0, 1, 3, 0, 0, 0), 1'b0, none},
            '{mk(FUNC_READ, 3, 0, 0, 0, 0, 0), 1'b1, '{10'd3, 24'd0, 24'd0, 24'd0}},
            '{mk(FUNC_LOAD, 1023, 0, 0, 32767, -32768, 32767), 1'b0, none},
            '{mk(FUNC_LOAD, 1022, 0, 0, -32768, 32767, -32768), 1'b0, none},
            '{mk(FUNC_LOAD, 1021, 0, 0, 32767, 32767, -32768), 1'b0, none},
            '{mk(FUNC_TRI, 1023, 1022, 1021, 0, 0, 0), 1'b0, none},
            '{mk(FUNC_TRI, 1021, 1023, 1022, 0, 0, 0), 1'b0, none},
            '{mk(FUNC_READ, 1023, 0, 0, 0, 0, 0), 1'b0, none},
            '{mk(FUNC_READ, 1022, 0, 0, 0, 0, 0), 1'b0, none},
            '{mk(FUNC_READ, 1021, 0, 0, 0, 0, 0), 1'b0, none}
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) send_word(dir_tab[i].cmd, dir_tab[i].typed,
                                                     dir_tab[i].sum);

        // drive one vertex to positive saturation, then another orientation to negative
        for (int pass = 0; pass < 2; pass++) begin
            send_word(mk(FUNC_LOAD, 100, 0, 0, 0, 0, 0), 1'b0, none);
            send_word(mk(FUNC_LOAD, 101, 0, 0, 256, 0, 0), 1'b0, none);
            send_word(mk(FUNC_LOAD, 102, 0, 0, 0, 256, 0), 1'b0, none);
            for (int i = 0; i < 520; i++)
                send_word(pass == 0 ? mk(FUNC_TRI, 100, 101, 102, 0, 0, 0)
                                    : mk(FUNC_TRI, 100, 102, 101, 0, 0, 0), 1'b0, none);
            send_word(mk(FUNC_READ, 100, 0, 0, 0, 0, 0), 1'b0, none);
            send_word(mk(FUNC_READ, 101, 0, 0, 0, 0, 0), 1'b0, none);
        end

        for (int i = 0; i < 560; i++) begin
            if (i == 200) begin
                drain_results();
                hold_long = 1'b1;
                for (int k = 0; k < 12; k++)
                    send_word(mk(FUNC_READ, pick_loaded(), 0, 0, 0, 0, 0), 1'b0, none);
            end
            r = $urandom_range(0, 99);
            if (r < 25) begin
                a = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 31) : $urandom_range(0, 1023);
                send_word(mk(FUNC_LOAD, a, $urandom_range(0, 1023), $urandom_range(0, 1023),
                             rand_pos(), rand_pos(), rand_pos()), 1'b0, none);
            end else if (r < 70) begin
                a = pick_loaded();
                b = pick_loaded();
                c = ($urandom_range(0, 9) == 0) ? a : pick_loaded();
                send_word(mk(FUNC_TRI, a, b, c, $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(0, 65535)), 1'b0, none);
            end else if (r < 94) begin
                send_word(mk(FUNC_READ, pick_loaded(), $urandom_range(0, 1023),
                             $urandom_range(0, 1023), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(0, 65535)), 1'b0, none);
            end else begin
                send_word(mk(FUNC_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(0, 1023), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(0, 65535)), 1'b0, none);
            end
        end

        drain_results();
        repeat (400) @(posedge aclk);
        if (fails == 0 && normal_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
